FILE: hw/rtl/rpee_pkg.sv
// Shared types and constants of the pair energy exchange block.
// No dependencies; imported by rpee_div and random_pair_energy_exchange.
package rpee_pkg;

   // field widths
   localparam int ENERGY_W = 48;
   localparam int TEMP_W   = 40;
   localparam int COUNT_W  = 10;
   localparam int TINIT_W  = 32;
   localparam int INDEX_W  = 10;
   localparam int FRAC_W   = 16;
   localparam int STATUS_W = 2;

   localparam int DEFAULT_MAX_MOLECULES = 1024;

   // operations
   localparam logic OP_INIT    = 1'b0;
   localparam logic OP_COLLIDE = 1'b1;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EQUAL = 2'd2;

   // register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_COUNT_A     = 2'd0;
   localparam logic [1:0] REG_COUNT_B     = 2'd1;
   localparam logic [1:0] REG_TEMP_A_INIT = 2'd2;
   localparam logic [1:0] REG_TEMP_B_INIT = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_A_RESET     = 10'd512;
   localparam logic [COUNT_W-1:0] COUNT_B_RESET     = 10'd512;
   localparam logic [TINIT_W-1:0] TEMP_A_INIT_RESET = 32'h0001_0000;
   localparam logic [TINIT_W-1:0] TEMP_B_INIT_RESET = 32'h0001_0000;

   // divider: 2*sum (49 bits) padded to an even width, 2 quotient bits a cycle
   localparam int DIV_NUM_W  = 50;
   localparam int DIV_DEN_W  = 12;
   localparam int DIV_STEPS  = DIV_NUM_W / 2;
   localparam int DIV_CNT_W  = 5;

   typedef struct packed {
      logic                op;
      logic [INDEX_W-1:0]  first_index;
      logic [INDEX_W-1:0]  second_index;
      logic [FRAC_W-1:0]   fraction;
   } req_type;

   typedef struct packed {
      logic [TEMP_W-1:0]   temp_a;
      logic [TEMP_W-1:0]   temp_b;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: hw/rtl/rpee_div.sv
// Restoring divider, two quotient bits per cycle, for the group temperatures.
// Depends on rpee_pkg.
module rpee_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rpee_pkg::div_req_type div_req,
   output rpee_pkg::div_rsp_type div_rsp
);
   import rpee_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;

   logic [DIV_DEN_W:0]   t1, d1, t2, d2;
   logic [DIV_DEN_W-1:0] r1, r2;
   logic                 ge1, ge2;

   // remainder stays below the divisor, so each trial fits one extra bit
   always_comb begin
      t1  = {rem_ff, num_ff[DIV_NUM_W-1]};
      d1  = t1 - {1'b0, den_ff};
      ge1 = (t1 >= {1'b0, den_ff});
      r1  = ge1 ? d1[DIV_DEN_W-1:0] : t1[DIV_DEN_W-1:0];
      t2  = {r1, num_ff[DIV_NUM_W-2]};
      d2  = t2 - {1'b0, den_ff};
      ge2 = (t2 >= {1'b0, den_ff});
      r2  = ge2 ? d2[DIV_DEN_W-1:0] : t2[DIV_DEN_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = div_req.dividend;
         den_in  = div_req.divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_NUM_W-3:0], 2'b00};
         rem_in = r2;
         quo_in = {quo_ff[DIV_NUM_W-3:0], ge1, ge2};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: hw/rtl/random_pair_energy_exchange.sv
// Top level of the pair energy exchange block: energy store, sums, sequencer.
// Depends on rpee_pkg and rpee_div.
//
// One 48-bit energy (Q32.16) per molecule lives in a single-port-write,
// dual-read synchronous memory of MAX_MOLECULES words. Molecules below
// count_a form group A, the next count_b form group B. An init word sets
// one energy to 1.5 times its group's initial temperature; a collide word
// pools two energies (saturated to 48 bits) and hands the first molecule
// the share fraction/65536, the second the rest. Exact, unsaturated group
// sums are kept in registers and updated by the energy change of each word;
// every word returns one result word with both temperatures
// floor(2*sum/(3*count)), sum saturated to 48 bits and the result to 40,
// plus a status (range error or equal indices: item ignored, temperatures
// still reported). Items are handled one at a time; the two temperature
// divisions run one after the other on the shared two-bits-per-cycle
// divider. A finished result sits in an output register, so the next word
// is taken while it waits. After reset the block runs a clearing pass that
// zeroes every entry, with req_stall high. A write to count_a or count_b
// changes the partition and triggers a resum pass that reads every entry
// once, again with req_stall high. The register port takes writes at all
// times and answers reads combinationally.
module random_pair_energy_exchange #(
   parameter int MAX_MOLECULES = rpee_pkg::DEFAULT_MAX_MOLECULES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rpee_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rpee_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rpee_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rpee_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rpee_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import rpee_pkg::*;

   localparam int IDX_W = (MAX_MOLECULES > 1) ? $clog2(MAX_MOLECULES) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam int CMP_W = (IDX_W + 1 > COUNT_W + 1) ? IDX_W + 1 : COUNT_W + 1;
   localparam int EXT_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
   localparam int SUM_W = ENERGY_W + IDX_W;
   localparam int PART_W = ENERGY_W + 1;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
   localparam logic [TEMP_W-1:0]   TEMP_MAX   = '1;

   // sequencer states
   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_SUM       = 4'd1;
   localparam logic [3:0] ST_IDLE      = 4'd2;
   localparam logic [3:0] ST_READ      = 4'd3;
   localparam logic [3:0] ST_CALC      = 4'd4;
   localparam logic [3:0] ST_MUL       = 4'd5;
   localparam logic [3:0] ST_WR1       = 4'd6;
   localparam logic [3:0] ST_WR2       = 4'd7;
   localparam logic [3:0] ST_ADD       = 4'd8;
   localparam logic [3:0] ST_DIVA_GO   = 4'd9;
   localparam logic [3:0] ST_DIVA_WAIT = 4'd10;
   localparam logic [3:0] ST_DIVB_GO   = 4'd11;
   localparam logic [3:0] ST_DIVB_WAIT = 4'd12;
   localparam logic [3:0] ST_DONE      = 4'd13;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [COUNT_W-1:0] count_a_ff, count_b_ff;
   logic [TINIT_W-1:0] temp_a_init_ff, temp_b_init_ff;
   logic [1:0]         csr_sel;
   logic               csr_wr;
   logic               count_write;

   assign pready      = 1'b1;
   assign csr_sel     = paddr[CSR_ADDR_W-1:2];
   assign csr_wr      = psel && penable && pwrite;
   assign count_write = csr_wr && (csr_sel == REG_COUNT_A || csr_sel == REG_COUNT_B);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff     <= COUNT_A_RESET;
         count_b_ff     <= COUNT_B_RESET;
         temp_a_init_ff <= TEMP_A_INIT_RESET;
         temp_b_init_ff <= TEMP_B_INIT_RESET;
      end else if (csr_wr) begin
         case (csr_sel)
            REG_COUNT_A:     count_a_ff     <= pwdata[COUNT_W-1:0];
            REG_COUNT_B:     count_b_ff     <= pwdata[COUNT_W-1:0];
            REG_TEMP_A_INIT: temp_a_init_ff <= pwdata[TINIT_W-1:0];
            REG_TEMP_B_INIT: temp_b_init_ff <= pwdata[TINIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         REG_COUNT_A:     prdata = CSR_DATA_W'(count_a_ff);
         REG_COUNT_B:     prdata = CSR_DATA_W'(count_b_ff);
         REG_TEMP_A_INIT: prdata = CSR_DATA_W'(temp_a_init_ff);
         REG_TEMP_B_INIT: prdata = CSR_DATA_W'(temp_b_init_ff);
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // energy store: one write port, two registered read ports
   // ---------------------------------------------------------------
   logic [ENERGY_W-1:0] energy_mem [MAX_MOLECULES];
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr, mem_raddr0, mem_raddr1;
   logic [ENERGY_W-1:0] mem_wdata;
   logic [ENERGY_W-1:0] rd0_ff, rd1_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         energy_mem[mem_waddr] <= mem_wdata;
      end
      rd0_ff <= energy_mem[mem_raddr0];
      rd1_ff <= energy_mem[mem_raddr1];
   end

   // ---------------------------------------------------------------
   // sequencer state
   // ---------------------------------------------------------------
   logic [3:0]          state_ff, state_in;
   logic                resync_pend_ff, resync_pend_in;
   logic [CNT_W-1:0]    sweep_cnt_ff, sweep_cnt_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [SUM_W-1:0]    sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // per-item payload
   req_type             item_ff, item_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                gi_a_ff, gi_a_in, gj_a_ff, gj_a_in;
   logic [ENERGY_W-1:0] pool_ff, pool_in;
   logic [ENERGY_W-1:0] init_e_ff, init_e_in;
   logic [PART_W-1:0]   old_a_ff, old_a_in, old_b_ff, old_b_in;
   logic [47:0]         prod_hi_ff, prod_hi_in;
   logic [31:0]         prod_lo_ff, prod_lo_in;
   logic [ENERGY_W-1:0] val_i_ff, val_i_in, val_j_ff, val_j_in;
   logic [TEMP_W-1:0]   temp_a_ff, temp_a_in, temp_b_ff, temp_b_in;

   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // index arithmetic
   logic [EXT_W-1:0]    i_ext, j_ext;
   logic [IDX_W-1:0]    addr_i, addr_j, sweep_addr;
   logic [CMP_W-1:0]    i_cmp, j_cmp, ca_cmp, total_cmp, max_cmp, rd_cmp;
   logic                i_ok, j_ok, sweep_end;

   assign i_ext      = EXT_W'(item_ff.first_index);
   assign j_ext      = EXT_W'(item_ff.second_index);
   assign addr_i     = i_ext[IDX_W-1:0];
   assign addr_j     = j_ext[IDX_W-1:0];
   assign sweep_addr = sweep_cnt_ff[IDX_W-1:0];
   assign sweep_end  = (sweep_cnt_ff == CNT_W'(MAX_MOLECULES));

   assign i_cmp     = CMP_W'(item_ff.first_index);
   assign j_cmp     = CMP_W'(item_ff.second_index);
   assign ca_cmp    = CMP_W'(count_a_ff);
   assign total_cmp = CMP_W'(count_a_ff) + CMP_W'(count_b_ff);
   assign max_cmp   = CMP_W'(MAX_MOLECULES);
   assign rd_cmp    = CMP_W'(rd_idx_ff);
   assign i_ok      = (i_cmp < total_cmp) && (i_cmp < max_cmp);
   assign j_ok      = (j_cmp < total_cmp) && (j_cmp < max_cmp);

   // datapath helpers
   logic [PART_W-1:0]   pool_raw;
   logic [TINIT_W-1:0]  tinit_sel;
   logic [TINIT_W+1:0]  tinit_x3;
   logic [ENERGY_W-1:0] share;
   logic                coll;
   logic [ENERGY_W-1:0] sum_sat_a, sum_sat_b;
   logic [TEMP_W-1:0]   q_sat;

   assign coll      = (item_ff.op == OP_COLLIDE);
   assign pool_raw  = {1'b0, rd0_ff} + {1'b0, rd1_ff};
   assign tinit_sel = gi_a_ff ? temp_a_init_ff : temp_b_init_ff;
   assign tinit_x3  = {2'b00, tinit_sel} + {1'b0, tinit_sel, 1'b0};
   assign share     = prod_hi_ff + ENERGY_W'(prod_lo_ff[31:16]);
   assign sum_sat_a = (sum_a_ff[SUM_W-1:ENERGY_W] != '0) ? ENERGY_MAX
                                                          : sum_a_ff[ENERGY_W-1:0];
   assign sum_sat_b = (sum_b_ff[SUM_W-1:ENERGY_W] != '0) ? ENERGY_MAX
                                                          : sum_b_ff[ENERGY_W-1:0];
   assign q_sat     = (div_rsp.quotient[DIV_NUM_W-1:TEMP_W] != '0) ? TEMP_MAX
                                                          : div_rsp.quotient[TEMP_W-1:0];

   // divider feed: dividend 2*sum, divisor 3*count
   always_comb begin
      div_req.start = (state_ff == ST_DIVA_GO) || (state_ff == ST_DIVB_GO);
      if (state_ff == ST_DIVB_GO) begin
         div_req.dividend = {1'b0, sum_sat_b, 1'b0};
         div_req.divisor  = {1'b0, count_b_ff, 1'b0} + {2'b00, count_b_ff};
      end else begin
         div_req.dividend = {1'b0, sum_sat_a, 1'b0};
         div_req.divisor  = {1'b0, count_a_ff, 1'b0} + {2'b00, count_a_ff};
      end
   end

   rpee_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // memory port steering
   always_comb begin
      mem_raddr0 = (state_ff == ST_SUM) ? sweep_addr : addr_i;
      mem_raddr1 = addr_j;
      mem_we     = 1'b0;
      mem_waddr  = addr_i;
      mem_wdata  = val_i_in;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = !sweep_end;
            mem_waddr = sweep_addr;
            mem_wdata = '0;
         end
         ST_WR1: begin
            mem_we = 1'b1;
         end
         ST_WR2: begin
            mem_we    = 1'b1;
            mem_waddr = addr_j;
            mem_wdata = val_j_in;
         end
         default: ;
      endcase
   end

   assign req_stall = !((state_ff == ST_IDLE) && !resync_pend_ff);

   // main sequencer
   always_comb begin
      state_in       = state_ff;
      resync_pend_in = resync_pend_ff || count_write;
      sweep_cnt_in   = sweep_cnt_ff;
      rd_valid_in    = 1'b0;
      rd_idx_in      = sweep_addr;
      sum_a_in       = sum_a_ff;
      sum_b_in       = sum_b_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      item_in        = item_ff;
      status_in      = status_ff;
      gi_a_in        = gi_a_ff;
      gj_a_in        = gj_a_ff;
      pool_in        = pool_ff;
      init_e_in      = init_e_ff;
      old_a_in       = old_a_ff;
      old_b_in       = old_b_ff;
      prod_hi_in     = pool_ff[ENERGY_W-1:16] * item_ff.fraction;
      prod_lo_in     = pool_ff[15:0] * item_ff.fraction;
      val_i_in       = coll ? share : init_e_ff;
      val_j_in       = pool_ff - val_i_ff;
      temp_a_in      = temp_a_ff;
      temp_b_in      = temp_b_ff;

      case (state_ff)
         ST_CLEAR: begin
            // zero every entry once; sums start at zero
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_end) begin
               sweep_cnt_in = sweep_cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_SUM: begin
            // issue one read a cycle, fold each returning word into its group
            if (!sweep_end) begin
               sweep_cnt_in = sweep_cnt_ff + 1'b1;
               rd_valid_in  = 1'b1;
            end
            if (rd_valid_ff) begin
               if (rd_cmp < ca_cmp) begin
                  sum_a_in = sum_a_ff + SUM_W'(rd0_ff);
               end else if (rd_cmp < total_cmp) begin
                  sum_b_in = sum_b_ff + SUM_W'(rd0_ff);
               end
            end
            if (sweep_end && !rd_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (resync_pend_ff) begin
               // partition moved: rebuild both sums from the store
               resync_pend_in = count_write;
               sweep_cnt_in   = '0;
               sum_a_in       = '0;
               sum_b_in       = '0;
               state_in       = ST_SUM;
            end else if (req_valid) begin
               item_in  = req_data;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // read ports address both molecules this cycle
            gi_a_in = (i_cmp < ca_cmp);
            gj_a_in = (j_cmp < ca_cmp);
            if (!i_ok) begin
               status_in = STATUS_RANGE;
            end else if (!coll) begin
               status_in = STATUS_OK;
            end else if (!j_ok) begin
               status_in = STATUS_RANGE;
            end else if (item_ff.first_index == item_ff.second_index) begin
               status_in = STATUS_EQUAL;
            end else begin
               status_in = STATUS_OK;
            end
            if (status_in == STATUS_OK) begin
               state_in = ST_CALC;
            end else begin
               state_in = ST_DIVA_GO;
            end
         end
         ST_CALC: begin
            pool_in   = pool_raw[ENERGY_W] ? ENERGY_MAX : pool_raw[ENERGY_W-1:0];
            init_e_in = ENERGY_W'(tinit_x3[TINIT_W+1:1]);
            old_a_in  = (gi_a_ff ? PART_W'(rd0_ff) : '0)
                      + ((coll && gj_a_ff) ? PART_W'(rd1_ff) : '0);
            old_b_in  = (!gi_a_ff ? PART_W'(rd0_ff) : '0)
                      + ((coll && !gj_a_ff) ? PART_W'(rd1_ff) : '0);
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            // take the old energies out of the sums while the share is formed
            sum_a_in = sum_a_ff - SUM_W'(old_a_ff);
            sum_b_in = sum_b_ff - SUM_W'(old_b_ff);
            state_in = ST_WR1;
         end
         ST_WR1: begin
            state_in = coll ? ST_WR2 : ST_ADD;
         end
         ST_WR2: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_a_in = sum_a_ff + SUM_W'(gi_a_ff ? val_i_ff : '0)
                                + SUM_W'((coll && gj_a_ff) ? val_j_ff : '0);
            sum_b_in = sum_b_ff + SUM_W'(!gi_a_ff ? val_i_ff : '0)
                                + SUM_W'((coll && !gj_a_ff) ? val_j_ff : '0);
            state_in = ST_DIVA_GO;
         end
         ST_DIVA_GO: begin
            state_in = ST_DIVA_WAIT;
         end
         ST_DIVA_WAIT: begin
            if (div_rsp.done) begin
               temp_a_in = (count_a_ff == '0) ? '0 : q_sat;
               state_in  = ST_DIVB_GO;
            end
         end
         ST_DIVB_GO: begin
            state_in = ST_DIVB_WAIT;
         end
         ST_DIVB_WAIT: begin
            if (div_rsp.done) begin
               temp_b_in = (count_b_ff == '0) ? '0 : q_sat;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.temp_a = temp_a_ff;
               rsp_data_in.temp_b = temp_b_ff;
               rsp_data_in.status = status_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         resync_pend_ff <= 1'b0;
         sweep_cnt_ff   <= '0;
         rd_valid_ff    <= 1'b0;
         sum_a_ff       <= '0;
         sum_b_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         resync_pend_ff <= resync_pend_in;
         sweep_cnt_ff   <= sweep_cnt_in;
         rd_valid_ff    <= rd_valid_in;
         sum_a_ff       <= sum_a_in;
         sum_b_ff       <= sum_b_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
      item_ff     <= item_in;
      status_ff   <= status_in;
      gi_a_ff     <= gi_a_in;
      gj_a_ff     <= gj_a_in;
      pool_ff     <= pool_in;
      init_e_ff   <= init_e_in;
      old_a_ff    <= old_a_in;
      old_b_ff    <= old_b_in;
      prod_hi_ff  <= prod_hi_in;
      prod_lo_ff  <= prod_lo_in;
      val_i_ff    <= val_i_in;
      val_j_ff    <= val_j_in;
      temp_a_ff   <= temp_a_in;
      temp_b_ff   <= temp_b_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // an ignored item never reaches the store
   a_no_write_on_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR1) |-> (status_ff == STATUS_OK))
      else $error("store written for an ignored item");

   // the two writes of a collision target distinct entries
   a_distinct_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR2) |-> (addr_i != addr_j))
      else $error("collision writes the same entry twice");

   // a collision hands out exactly the pooled energy
   a_pool_conserved: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && coll) |->
         (({1'b0, val_i_ff} + {1'b0, val_j_ff}) == {1'b0, pool_ff}))
      else $error("collision does not conserve the pool");

endmodule

FILE: bench/random_pair_energy_exchange_test.sv
`timescale 1ns / 1ps
// Self-checking bench for random_pair_energy_exchange: directed plan, then random traffic.
// Depends on rpee_pkg and the block's RTL; carries its own energy store and temperature predictor.
module random_pair_energy_exchange_test;
   import rpee_pkg::*;

   localparam int MOLECULES = DEFAULT_MAX_MOLECULES;
   // Longest quiet stretch in a correct run: resum pass or the receiver
   // hold-off plus one item, well under this.
   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_OFF     = 300;
   localparam int DRAIN_CYCLES = 100;
   localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
   localparam longint unsigned MASK40 = 64'hFF_FFFF_FFFF;

   typedef enum bit {ROW_WORD, ROW_WRITE} row_kind_e;

   typedef struct {
      row_kind_e  kind;
      logic [1:0] reg_idx;
      logic [31:0] value;
      req_type    word;
      bit         pinned;
      rsp_type    result;
   } plan_row;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // mirror of the block's state and registers
   logic [ENERGY_W-1:0] energy_of [MOLECULES];
   logic [COUNT_W-1:0]  cnt_a;
   logic [COUNT_W-1:0]  cnt_b;
   logic [TINIT_W-1:0]  init_a;
   logic [TINIT_W-1:0]  init_b;

   rsp_type pending_temps[$];
   plan_row opening_plan[$];
   int      errors;
   int      quiet;
   bit      steady;      // both sides stop idling while set
   bit      flood_req;   // ask the receiver for one long hold-off
   bit      bus_open;
   bit      pinned_on;
   rsp_type pinned_rsp;

   random_pair_energy_exchange u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Temperature of the molecules in [lo, hi): sum saturated to 48 bits,
   // then 2*sum/(3*count) saturated to 40 bits. Indices past the store
   // do not exist and add nothing.
   function automatic logic [TEMP_W-1:0] group_temperature(int lo, int hi, int count);
      longint unsigned sum;
      longint unsigned den;
      longint unsigned quot;
      sum = 0;
      if (hi > MOLECULES) hi = MOLECULES;
      for (int k = lo; k < hi; k++) sum += energy_of[k];
      if (sum > MASK48) sum = MASK48;
      if (count == 0) return '0;
      den  = count;
      quot = (sum * 2) / (den * 3);
      if (quot > MASK40) quot = MASK40;
      return TEMP_W'(quot);
   endfunction

   // Apply one word to the mirrored store and return the result it yields.
   function automatic rsp_type exchange_energy(req_type w);
      rsp_type         r;
      int              total;
      longint unsigned heat;
      longint unsigned ea;
      longint unsigned eb;
      longint unsigned pool;
      longint unsigned share;
      total    = int'(cnt_a) + int'(cnt_b);
      r.status = STATUS_OK;
      if (int'(w.first_index) >= total) begin
         r.status = STATUS_RANGE;
      end else if (w.op == OP_INIT) begin
         heat = (w.first_index < cnt_a) ? init_a : init_b;
         energy_of[w.first_index] = ENERGY_W'((heat * 3) >> 1);
      end else if (int'(w.second_index) >= total) begin
         r.status = STATUS_RANGE;
      end else if (w.first_index == w.second_index) begin
         r.status = STATUS_EQUAL;
      end else begin
         ea   = energy_of[w.first_index];
         eb   = energy_of[w.second_index];
         pool = ea + eb;
         if (pool > MASK48) pool = MASK48;
         share = (pool * w.fraction) >> 16;
         energy_of[w.first_index]  = ENERGY_W'(share);
         energy_of[w.second_index] = ENERGY_W'(pool - share);
      end
      // sums follow the current partition, whatever the counts were before
      r.temp_a = group_temperature(0, cnt_a, cnt_a);
      r.temp_b = group_temperature(cnt_a, int'(cnt_a) + int'(cnt_b), cnt_b);
      return r;
   endfunction

   function automatic req_type make_word(logic op, int i, int j, int frac);
      req_type w;
      w.op           = op;
      w.first_index  = INDEX_W'(i);
      w.second_index = INDEX_W'(j);
      w.fraction     = FRAC_W'(frac);
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Directed plan rows
   // ------------------------------------------------------------------

   function automatic void add_word(logic op, int i, int j, int frac, bit pin,
                                    longint unsigned ta, longint unsigned tb,
                                    logic [STATUS_W-1:0] st);
      plan_row r;
      r.kind           = ROW_WORD;
      r.reg_idx        = '0;
      r.value          = '0;
      r.word           = make_word(op, i, j, frac);
      r.pinned         = pin;
      r.result.temp_a  = TEMP_W'(ta);
      r.result.temp_b  = TEMP_W'(tb);
      r.result.status  = st;
      opening_plan.push_back(r);
   endfunction

   function automatic void add_write(logic [1:0] idx, logic [31:0] value);
      plan_row r;
      r.kind    = ROW_WRITE;
      r.reg_idx = idx;
      r.value   = value;
      r.word    = '0;
      r.pinned  = 1'b0;
      r.result  = '0;
      opening_plan.push_back(r);
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic compare_result(rsp_type want, rsp_type got);
      if (got.temp_a !== want.temp_a) begin
         $display("%0t: temp_a expected %h, got %h", $time, want.temp_a, got.temp_a);
         errors++;
      end
      if (got.temp_b !== want.temp_b) begin
         $display("%0t: temp_b expected %h, got %h", $time, want.temp_b, got.temp_b);
         errors++;
      end
      if (got.status !== want.status) begin
         $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
         errors++;
      end
   endtask

   // Sample both channels at the edge. Retire the result first: a result
   // leaving at the same edge as a word entering belongs to an older word.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_temps.size() == 0) begin
               $display("%0t: result expected none, got %h", $time, rsp_data);
               errors++;
            end else begin
               want = pending_temps.pop_front();
               compare_result(want, rsp_data);
            end
         end
         if (req_valid && !req_stall) begin
            want = exchange_energy(req_data);
            pending_temps.push_back(pinned_on ? pinned_rsp : want);
         end
      end
   end

   // Watchdog: count edges with no word moving on either channel or the bus.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         quiet <= 0;
      end else if (quiet == STALL_LIMIT) begin
         $display("random_pair_energy_exchange_test: done, errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls, one long hold-off on request
   // ------------------------------------------------------------------

   initial begin
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (flood_req) begin
            // hold off long enough for the block to fill and stall its input
            flood_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= (!steady && $urandom_range(99) < 28);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender and register access
   // ------------------------------------------------------------------

   // Offer one word, idling first at random; return at the accepting edge.
   // Valid stays high when the next word follows at once.
   task automatic send_word(req_type w, bit pin, rsp_type fixed);
      int gap;
      gap = 0;
      while (!steady && $urandom_range(99) < 28) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_data   <= w;
      pinned_on  <= pin;
      pinned_rsp <= fixed;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every pending result is back.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_temps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register, then read it back. Leave the bus in its access
   // phase so that a following transfer can start at the same edge.
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      logic [31:0] kept;
      case (idx)
         REG_COUNT_A, REG_COUNT_B: kept = {22'b0, value[COUNT_W-1:0]};
         default:                  kept = value;
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // the write lands at this edge: mirror it
      case (idx)
         REG_COUNT_A:     cnt_a  = kept[COUNT_W-1:0];
         REG_COUNT_B:     cnt_b  = kept[COUNT_W-1:0];
         REG_TEMP_A_INIT: init_a = kept;
         REG_TEMP_B_INIT: init_b = kept;
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== kept) begin
         $display("%0t: register %0d expected %h, got %h", $time, idx, kept, prdata);
         errors++;
      end
   endtask

   // New setting for all four registers; counts carry junk above bit 9.
   task automatic configure(int ca, int cb, logic [31:0] ta, logic [31:0] tb);
      settle_block();
      write_reg(REG_COUNT_A, ($urandom & 32'hFFFF_FC00) | ca);
      write_reg(REG_COUNT_B, ($urandom & 32'hFFFF_FC00) | cb);
      write_reg(REG_TEMP_A_INIT, ta);
      write_reg(REG_TEMP_B_INIT, tb);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Mostly in-range traffic, with equal pairs and raw 10-bit indices mixed in.
   task automatic run_random(int words, bit flood);
      req_type w;
      int      limit;
      int      roll;
      limit = int'(cnt_a) + int'(cnt_b);
      if (limit > MOLECULES) limit = MOLECULES;
      for (int k = 0; k < words; k++) begin
         if (flood && k == words / 2) flood_req = 1'b1;
         roll = $urandom_range(99);
         w = make_word(($urandom_range(99) < 60) ? OP_COLLIDE : OP_INIT,
                       $urandom_range(limit - 1), $urandom_range(limit - 1), $urandom);
         if (roll < 10) begin
            w.second_index = w.first_index;
         end else if (roll < 22) begin
            w.first_index  = INDEX_W'($urandom);
            w.second_index = INDEX_W'($urandom);
         end
         if ($urandom_range(9) == 0) w.fraction = $urandom_range(1) ? '1 : '0;
         send_word(w, 1'b0, '0);
      end
   endtask

   // Pile the energy of freshly heated group B molecules onto molecule 0,
   // the only group A molecule, until its temperature saturates.
   task automatic run_heat_pump(int pairs);
      int k;
      configure(1, 1023, $urandom, 32'hFFFF_FFFF);
      for (int p = 0; p < pairs; p++) begin
         k = $urandom_range(1023, 1);
         send_word(make_word(OP_INIT, k, $urandom_range(1023), $urandom), 1'b0, '0);
         if ($urandom_range(1))
            send_word(make_word(OP_COLLIDE, 0, k, $urandom_range(16'hFFFF, 16'hFFF0)),
                      1'b0, '0);
         else
            send_word(make_word(OP_COLLIDE, k, 0, $urandom_range(15, 0)), 1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_stall  = 1'b0;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      pinned_on  = 1'b0;
      pinned_rsp = '0;
      steady     = 1'b0;
      flood_req  = 1'b0;
      bus_open   = 1'b0;
      errors     = 0;
      quiet      = 0;
      cnt_a      = COUNT_A_RESET;
      cnt_b      = COUNT_B_RESET;
      init_a     = TEMP_A_INIT_RESET;
      init_b     = TEMP_B_INIT_RESET;
      foreach (energy_of[k]) energy_of[k] = '0;

      // Reset setting: 512 + 512 molecules at temperature 1.0. One init
      // energy is 1.5, so one molecule over 512 reads as temperature 128.
      add_word(OP_COLLIDE, 0, 1, 16'h0000, 1, 0, 0, STATUS_OK);
      add_word(OP_INIT, 1023, 0, 16'h0000, 1, 0, 128, STATUS_OK);
      add_word(OP_INIT, 0, 1023, 16'hFFFF, 1, 128, 128, STATUS_OK);
      add_word(OP_COLLIDE, 7, 7, 16'h8000, 1, 128, 128, STATUS_EQUAL);
      add_word(OP_COLLIDE, 0, 1023, 16'hFFFF, 0, 0, 0, STATUS_OK);
      add_word(OP_COLLIDE, 1023, 0, 16'h0000, 0, 0, 0, STATUS_OK);
      add_word(OP_COLLIDE, 511, 512, 16'h8000, 0, 0, 0, STATUS_OK);
      add_word(OP_INIT, 512, 0, 16'h0000, 0, 0, 0, STATUS_OK);
      // smallest groups, hottest A and coldest B: indices past the groups give range errors
      add_write(REG_COUNT_A, 32'd1);
      add_write(REG_COUNT_B, 32'd1);
      add_write(REG_TEMP_A_INIT, 32'hFFFF_FFFF);
      add_write(REG_TEMP_B_INIT, 32'h0000_0000);
      add_word(OP_INIT, 0, 0, 16'h0000, 0, 0, 0, STATUS_OK);
      add_word(OP_INIT, 1, 0, 16'h0000, 0, 0, 0, STATUS_OK);
      add_word(OP_INIT, 2, 0, 16'h0000, 0, 0, 0, STATUS_OK);
      add_word(OP_COLLIDE, 0, 1023, 16'hFFFF, 0, 0, 0, STATUS_OK);
      add_word(OP_COLLIDE, 1023, 0, 16'hFFFF, 0, 0, 0, STATUS_OK);
      add_word(OP_COLLIDE, 1, 1, 16'h1234, 0, 0, 0, STATUS_OK);
      add_word(OP_COLLIDE, 0, 1, 16'h0001, 0, 0, 0, STATUS_OK);
      add_word(OP_COLLIDE, 1, 0, 16'hFFFF, 0, 0, 0, STATUS_OK);
      // count_a keeps only its low 10 bits: empty group A, 1023 in group B
      add_write(REG_COUNT_A, 32'hFFFF_FC00);
      add_write(REG_COUNT_B, 32'h0000_03FF);
      add_write(REG_TEMP_A_INIT, 32'h0000_0000);
      add_write(REG_TEMP_B_INIT, 32'hFFFF_FFFF);
      add_word(OP_INIT, 1023, 0, 16'h0000, 0, 0, 0, STATUS_OK);
      add_word(OP_INIT, 1022, 0, 16'h0000, 0, 0, 0, STATUS_OK);
      add_word(OP_COLLIDE, 0, 1022, 16'h5555, 0, 0, 0, STATUS_OK);
      // largest groups: group B runs past the end of the store
      add_write(REG_COUNT_A, 32'h0000_03FF);
      add_write(REG_COUNT_B, 32'hFFFF_FFFF);
      add_word(OP_INIT, 1023, 0, 16'h0000, 0, 0, 0, STATUS_OK);
      add_word(OP_COLLIDE, 0, 1023, 16'h8000, 0, 0, 0, STATUS_OK);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Walk the plan. Settle before the first write of a group; close the
      // bus before the next word.
      foreach (opening_plan[n]) begin
         if (opening_plan[n].kind == ROW_WRITE) begin
            if (!bus_open) settle_block();
            write_reg(opening_plan[n].reg_idx, opening_plan[n].value);
            bus_open = 1'b1;
         end else begin
            if (bus_open) begin
               psel    <= 1'b0;
               penable <= 1'b0;
               bus_open = 1'b0;
            end
            send_word(opening_plan[n].word, opening_plan[n].pinned, opening_plan[n].result);
         end
      end

      // Random part. The first phase runs with no idling on either side.
      steady = 1'b1;
      configure(1023, 1023, $urandom, $urandom);
      run_random(50, 1'b0);
      steady = 1'b0;
      configure(0, $urandom_range(1023, 1), $urandom, $urandom);
      run_random(30, 1'b0);
      // few molecules: dense collisions, many range errors, one long hold-off
      configure($urandom_range(6, 1), $urandom_range(6, 1), $urandom, $urandom);
      run_random(70, 1'b1);
      configure($urandom_range(1023, 1), $urandom_range(1023, 1), $urandom, $urandom);
      run_random(50, 1'b0);
      run_heat_pump(270);

      // drain, then give the block time to show any stray result
      settle_block();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("random_pair_energy_exchange_test: done, clean");
      else
         $display("random_pair_energy_exchange_test: done, errors");
      $finish;
   end

endmodule
